/* sv/bounded_deque_with_remove_macros.svh */
// assertion macros shared by the deque checker
// no dependencies; included by files that assert
`ifndef BOUNDED_DEQUE_WITH_REMOVE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define BDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bdq_pkg.sv */
// shared types and codes for the bounded deque
// no dependencies; imported by the cell, the top level and the checker
package bdq_pkg;

    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 5;
    localparam int MODE_W  = 3;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REMOVE     = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // cell commands
    localparam logic [MODE_W-1:0] CM_HOLD = 3'd0;
    localparam logic [MODE_W-1:0] CM_CMP  = 3'd1;
    localparam logic [MODE_W-1:0] CM_SHUP = 3'd2;
    localparam logic [MODE_W-1:0] CM_LOAD = 3'd3;
    localparam logic [MODE_W-1:0] CM_SHDN = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

/* sv/bdq_cell.sv */
// one slot of the deque chain: holds an entry, shifts to or from its neighbors
// depends on bdq_pkg
module bdq_cell import bdq_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0] i_cnt,
    input  logic                      i_shift,
    input  logic [DATA_W-1:0]         i_prev,
    input  logic [DATA_W-1:0]         i_next,
    output logic [DATA_W-1:0]         o_data,
    output logic                      o_match
);

    localparam int CW = $clog2(DEPTH+1);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              r_match;
    logic              n_match;

    always_comb begin
        n_data  = r_data;
        n_match = r_match;
        unique case (i_ctl.mode)
            CM_CMP: begin
                n_match = (r_data == i_ctl.value) && (i_cnt > CW'(IDX));
            end
            CM_SHUP: begin
                n_data = i_prev;
            end
            CM_LOAD: begin
                if (i_cnt == CW'(IDX)) begin
                    n_data = i_ctl.value;
                end
            end
            CM_SHDN: begin
                if (i_shift) begin
                    n_data = i_next;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

/* sv/bounded_deque_with_remove.sv */
// top level of the bounded deque: control sequencer, count and a chain of bdq_cell slots
// depends on bdq_pkg and bdq_cell
//
// Bounded double-ended queue of DEPTH signed 32-bit entries, one operation per item:
// push front, push back, pop front, pop back, remove the first entry equal to a value
// (counted from the front), or peek (codes six and seven also peek). Each item returns
// the front and back entries (0 when empty), the count and a status. Items are taken one
// at a time: push, pop and peek pass the update and result states; remove first passes
// the compare and prefix states, as the slots compare in parallel and a log2(DEPTH)-step
// prefix OR then marks every slot from the first match onward, which shift down together.
// A finished result waits in its own register, so the next item can be accepted while it
// is still stalled; a new result is written only once the previous one has been taken.
module bounded_deque_with_remove import bdq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_front_value,
    output logic signed [DATA_W-1:0] o_back_value,
    output logic [OCNT_W-1:0]        o_entry_count,
    output logic [STAT_W-1:0]        o_status
);

    localparam int CW = $clog2(DEPTH+1);
    localparam int LG = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_PFX  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_RES  = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [FUNC_W-1:0] r_func;
    logic [DATA_W-1:0] r_value;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;
    logic [DEPTH-1:0]  r_pfx;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_front;
    logic [DATA_W-1:0] r_back;
    logic [OCNT_W-1:0] r_ocnt;
    logic [STAT_W-1:0] r_ostat;

    t_cell_ctl         w_ctl;
    logic [DEPTH-1:0]  w_shift;
    logic [DEPTH-1:0]  w_match;
    logic [DEPTH-1:0]  w_pfx;
    logic [DATA_W-1:0] w_data [DEPTH];
    logic [DATA_W-1:0] w_back;
    logic              w_full;
    logic              w_empty;
    logic              w_accept;
    logic              w_out_free;
    logic [CW+OCNT_W-1:0] w_cnt_ext;

    assign w_full     = (r_cnt == CW'(DEPTH));
    assign w_empty    = (r_cnt == '0);
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    // prefix or: bit i set when some slot at or before i matched
    always_comb begin
        w_pfx = w_match;
        for (int k = 0; k < LG; k++) begin
            w_pfx = w_pfx | (w_pfx << (1 << k));
        end
    end

    assign w_shift = (r_func == FN_POP_FRONT) ? '1 : r_pfx;

    // command to the chain and the update of count and status
    always_comb begin
        w_ctl.mode  = CM_HOLD;
        w_ctl.value = r_value;
        n_cnt       = r_cnt;
        n_status    = r_status;
        if (r_state == S_CMP) begin
            w_ctl.mode = CM_CMP;
        end else if (r_state == S_UPD) begin
            n_status = ST_DONE;
            unique case (r_func)
                FN_PUSH_FRONT, FN_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.mode = (r_func == FN_PUSH_FRONT) ? CM_SHUP : CM_LOAD;
                        n_cnt      = r_cnt + CW'(1);
                    end
                end
                FN_POP_FRONT, FN_POP_BACK: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        if (r_func == FN_POP_FRONT) begin
                            w_ctl.mode = CM_SHDN;
                        end
                        n_cnt = r_cnt - CW'(1);
                    end
                end
                FN_REMOVE: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else if (!r_pfx[DEPTH-1]) begin
                        n_status = ST_NOTFOUND;
                    end else begin
                        w_ctl.mode = CM_SHDN;
                        n_cnt      = r_cnt - CW'(1);
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    // back entry: one-hot select of the slot at count minus one
    always_comb begin
        w_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_cnt == CW'(i + 1)) begin
                w_back = w_back | w_data[i];
            end
        end
    end

    assign w_cnt_ext = {{OCNT_W{1'b0}}, r_cnt};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_func == FN_REMOVE) ? S_CMP : S_UPD;
                end
            end
            S_CMP:   n_state = S_PFX;
            S_PFX:   n_state = S_UPD;
            S_UPD:   n_state = S_RES;
            S_RES: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_RES) && w_out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
        if (r_state == S_PFX) begin
            r_pfx <= w_pfx;
        end
        r_status <= n_status;
        if ((r_state == S_RES) && w_out_free) begin
            r_front <= w_empty ? '0 : w_data[0];
            r_back  <= w_back;
            r_ocnt  <= w_cnt_ext[OCNT_W-1:0];
            r_ostat <= r_status;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = r_value;
        end else begin : g_mid_prev
            assign w_prev = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid_next
            assign w_next = w_data[g+1];
        end
        bdq_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_cnt   (r_cnt),
            .i_shift (w_shift[g]),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_entry_count = r_ocnt;
    assign o_status      = r_ostat;

endmodule

/* sv/bdq_checker.sv */
// port-level checks for the bounded deque, bound to the top level
// depends on bdq_pkg and bounded_deque_with_remove_macros.svh
`include "bounded_deque_with_remove_macros.svh"

module bdq_checker import bdq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [DATA_W-1:0] o_front_value,
    input logic signed [DATA_W-1:0] o_back_value,
    input logic [OCNT_W-1:0]        o_entry_count,
    input logic [STAT_W-1:0]        o_status
);

    localparam logic [OCNT_W-1:0] FULL_CNT = OCNT_W'(DEPTH);
    localparam bit                NARROW   = (DEPTH < 32);

    // a full refusal reports the full count
    `BDQ_ASSERT_NOW(a_full_cnt, i_clk, i_rst_n, o_valid && (o_status == ST_FULL), o_entry_count == FULL_CNT, "full status with wrong count")

    // an empty refusal reports no entries
    `BDQ_ASSERT_NOW(a_empty_cnt, i_clk, i_rst_n, o_valid && (o_status == ST_EMPTY), o_entry_count == '0, "empty status with entries held")

    // an empty deque shows zero at both ends
    `BDQ_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_valid && NARROW && (o_entry_count == '0), (o_front_value == '0) && (o_back_value == '0), "empty deque with nonzero ends")

    // a single entry is both front and back
    `BDQ_ASSERT_NOW(a_single, i_clk, i_rst_n, o_valid && NARROW && (o_entry_count == OCNT_W'(1)), o_front_value == o_back_value, "single entry with differing ends")

    // a stalled item holds
    `BDQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_front_value) && $stable(o_back_value) && $stable(o_entry_count) && $stable(o_status), "stalled item changed")

endmodule

bind bounded_deque_with_remove bdq_checker #(
    .DEPTH (DEPTH)
) u_bdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_front_value (o_front_value),
    .o_back_value  (o_back_value),
    .o_entry_count (o_entry_count),
    .o_status      (o_status)
);
